// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the trigraph and splice block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ctsp_pkg.sv
// Types, character codes and the trigraph table of the trigraph and splice block.
// Depends on nothing; imported by every module of the block.
package ctsp_pkg;

    // What is held back while waiting for more lookahead.
    typedef enum logic [1:0] {
        PK_NONE,
        PK_Q1,
        PK_Q2,
        PK_BSL
    } pend_t;

    // How an emitted character moves the position.
    typedef enum logic [1:0] {
        ACT_COL1,
        ACT_COL3,
        ACT_NEWLINE
    } act_t;

    localparam int SLOTS   = 3;
    localparam int N_W     = 2;
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = 2;
    localparam int CNT_W   = 3;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [7:0] ch;
        act_t       act;
    } slot_t;

    // One queue entry: the characters that one input word releases.
    typedef struct packed {
        logic [N_W-1:0]         n;
        logic                   splice;
        slot_t [SLOTS-1:0]      slot;
    } rec_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } tri_t;

    // Third character of a trigraph to its replacement.
    function automatic tri_t tri_map(logic [7:0] b);
        tri_t r;
        r.hit = 1'b1;
        case (b)
            CH_EQ:    r.ch = CH_HASH;
            CH_LPAR:  r.ch = CH_LBRK;
            CH_RPAR:  r.ch = CH_RBRK;
            CH_SLASH: r.ch = CH_BSL;
            CH_APOS:  r.ch = CH_CARET;
            CH_LT:    r.ch = CH_LBRC;
            CH_GT:    r.ch = CH_RBRC;
            CH_EXCL:  r.ch = CH_BAR;
            CH_MINUS: r.ch = CH_TILDE;
            default: begin
                r.hit = 1'b0;
                r.ch  = b;
            end
        endcase
        return r;
    endfunction

    // Append one character to an entry.
    function automatic rec_t rec_add(rec_t r, logic [7:0] c, act_t a);
        rec_t o;
        o = r;
        o.slot[r.n].ch  = c;
        o.slot[r.n].act = a;
        o.n = r.n + N_W'(1);
        return o;
    endfunction

endpackage

// File: design/ctsp_front.sv
// Front end: holds lookahead bytes and queues what each input word releases or splices.
// Depends on ctsp_pkg.
module ctsp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // in_byte
    input  logic          s_tlast,   // end_of_input
    input  logic          q_full,
    output logic          push,
    output ctsp_pkg::rec_t rec
);
    import ctsp_pkg::*;

    pend_t pend_reg, pend_next;
    tri_t  tri_hit;
    logic  do_plain;
    logic  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign tri_hit  = tri_map(s_tdata);

    // Lookahead state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PK_NONE;
        end else if (accept) begin
            pend_reg <= pend_next;
        end
    end

    // Classify the word against what is held.
    always_comb begin
        rec       = '0;
        pend_next = pend_reg;
        do_plain  = 1'b0;
        if (s_tlast) begin
            case (pend_reg)
                PK_Q1: rec = rec_add(rec, CH_QMARK, ACT_COL1);
                PK_Q2: begin
                    rec = rec_add(rec, CH_QMARK, ACT_COL1);
                    rec = rec_add(rec, CH_QMARK, ACT_COL1);
                end
                PK_BSL: rec = rec_add(rec, CH_BSL, ACT_COL1);
                default: rec = '0;
            endcase
            pend_next = PK_NONE;
        end else begin
            case (pend_reg)
                PK_NONE: do_plain = 1'b1;
                PK_Q1: begin
                    if (s_tdata == CH_QMARK) begin
                        pend_next = PK_Q2;
                    end else begin
                        rec       = rec_add(rec, CH_QMARK, ACT_COL1);
                        pend_next = PK_NONE;
                        do_plain  = 1'b1;
                    end
                end
                PK_Q2: begin
                    if (tri_hit.hit) begin
                        rec       = rec_add(rec, tri_hit.ch, ACT_COL3);
                        pend_next = PK_NONE;
                    end else if (s_tdata == CH_QMARK) begin
                        // A third question mark releases one, two stay held.
                        rec = rec_add(rec, CH_QMARK, ACT_COL1);
                    end else begin
                        rec       = rec_add(rec, CH_QMARK, ACT_COL1);
                        rec       = rec_add(rec, CH_QMARK, ACT_COL1);
                        pend_next = PK_NONE;
                        do_plain  = 1'b1;
                    end
                end
                PK_BSL: begin
                    pend_next = PK_NONE;
                    if (s_tdata == CH_NL) begin
                        rec.splice = 1'b1;
                    end else begin
                        rec      = rec_add(rec, CH_BSL, ACT_COL1);
                        do_plain = 1'b1;
                    end
                end
                default: pend_next = PK_NONE;
            endcase
            // The byte itself, seen with nothing held.
            if (do_plain) begin
                if (s_tdata == CH_QMARK) begin
                    pend_next = PK_Q1;
                end else if (s_tdata == CH_BSL) begin
                    pend_next = PK_BSL;
                end else if (s_tdata == CH_NL) begin
                    rec = rec_add(rec, CH_NL, ACT_NEWLINE);
                end else begin
                    rec = rec_add(rec, s_tdata, ACT_COL1);
                end
            end
        end
    end

    // Only words that release characters or splice a line need the back end.
    assign push = accept && ((rec.n != '0) || rec.splice);

endmodule

// File: design/ctsp_queue.sv
// Short queue of entries between the front and the back end.
// Depends on ctsp_pkg.
module ctsp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ctsp_pkg::rec_t push_rec,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output ctsp_pkg::rec_t head
);
    import ctsp_pkg::*;

    rec_t             mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: design/ctsp_back.sv
// Back end: keeps line and column; one character per cycle leaves the queue head unless stalled.
// Depends on ctsp_pkg.
module ctsp_back #(
    parameter int LINE_BITS = 24,
    parameter int COL_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  ctsp_pkg::rec_t       head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           out_char,
    output logic [LINE_BITS-1:0] line_no,
    output logic [COL_BITS-1:0]  column_no,
    output logic                 m_tlast
);
    import ctsp_pkg::*;

    logic [LINE_BITS-1:0] line_reg, line_next, line_inc;
    logic [COL_BITS-1:0]  col_reg, col_next, col_adv;
    logic [COL_BITS:0]    col_sum;
    logic [N_W-1:0]       idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           char_reg;
    logic [LINE_BITS-1:0] line_out_reg;
    logic [COL_BITS-1:0]  col_out_reg;
    logic                 last_reg;
    logic                 out_free, load, is_last;
    slot_t                cur;

    assign out_free = !valid_reg || m_tready;
    assign cur      = head.slot[idx_reg];
    assign is_last  = (idx_reg == head.n - N_W'(1));

    // Saturating position arithmetic.
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
    assign col_sum  = {1'b0, col_reg} + ((cur.act == ACT_COL3) ? (COL_BITS+1)'(3)
                                                               : (COL_BITS+1)'(1));
    assign col_adv  = col_sum[COL_BITS] ? '1 : col_sum[COL_BITS-1:0];

    // Step through the head entry.
    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        idx_next  = idx_reg;
        pop       = 1'b0;
        load      = 1'b0;
        if (!q_empty) begin
            if (head.splice) begin
                line_next = line_inc;
                col_next  = '0;
                pop       = 1'b1;
            end else if (out_free) begin
                load = 1'b1;
                case (cur.act)
                    ACT_NEWLINE: begin
                        line_next = line_inc;
                        col_next  = '0;
                    end
                    default: col_next = col_adv;
                endcase
                if (is_last) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + N_W'(1);
                end
            end
        end
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Control and position registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            line_reg  <= line_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg     <= cur.ch;
            line_out_reg <= line_next;
            col_out_reg  <= col_next;
            last_reg     <= is_last;
        end
    end

    assign m_tvalid  = valid_reg;
    assign out_char  = char_reg;
    assign line_no   = line_out_reg;
    assign column_no = col_out_reg;
    assign m_tlast   = last_reg;

endmodule

// File: design/c_trigraph_splice_position.sv
// Top level of the trigraph replacement and line splice block.
// Depends on ctsp_pkg, ctsp_front, ctsp_queue, ctsp_back and assert_macros.svh.
//
// Usage:
// The slave side takes one source byte per word on s_tdata; a word with s_tlast
// high is an end marker whose byte is ignored and which flushes held bytes.
// The master side gives one translated character per word with the line and
// column reached after it; m_tlast marks the final character caused by one
// input word. Words that only hold lookahead or remove a splice give nothing.
// A character passes through a queue entry and the output register before it
// appears on m_tvalid. Throughput: one input word per cycle while each releases
// at most one character and the receiver keeps up; a word that releases two or
// three characters holds the back end until each has gone out, and the four-entry
// queue between front and back end absorbs such bursts. s_tready drops only when
// that queue is full, so a stalled receiver backs up through the output register
// and the queue before the input stalls. After reset nothing is held, the line
// is 1 and the column is 0; both counters saturate at all ones.
`include "assert_macros.svh"
module c_trigraph_splice_position #(
    parameter int LINE_BITS = 24,
    parameter int COL_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((8 + LINE_BITS + COL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
                                   // out_char, line_no, column_no, zero fill
    output logic        m_tlast    // last_of_run
);
    import ctsp_pkg::*;

    localparam int PAY_W  = 8 + LINE_BITS + COL_BITS;
    localparam int DATA_W = ((PAY_W + 7) / 8) * 8;

    logic                 q_full, q_empty, push, pop;
    rec_t                 push_rec, head;
    logic [7:0]           out_char;
    logic [LINE_BITS-1:0] line_no;
    logic [COL_BITS-1:0]  column_no;

    ctsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .rec      (push_rec)
    );

    ctsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    ctsp_back #(
        .LINE_BITS (LINE_BITS),
        .COL_BITS  (COL_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_char  (out_char),
        .line_no   (line_no),
        .column_no (column_no),
        .m_tlast   (m_tlast)
    );

    // Pack the result word, first field in the low bits.
    assign m_tdata = DATA_W'({column_no, line_no, out_char});

    // Line numbering starts at one and never wraps.
    `ASSERT_NEVER(a_line_nonzero, aclk, aresetn, m_tvalid && (line_no == '0))
    // Column zero is shown with an output character only for a newline.
    `ASSERT_IMPLIES(a_col0_newline, aclk, aresetn, m_tvalid && (column_no == '0), out_char == CH_NL)
    // A newline always restarts the column.
    `ASSERT_IMPLIES(a_newline_col0, aclk, aresetn, m_tvalid && (out_char == CH_NL), column_no == '0)

endmodule

// File: verif/ctsp_char_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the trigraph and splice block: watches both stream channels,
// works out the translated characters with their positions, and compares.
// Depends on ctsp_pkg for the character codes and the hold and position kinds.
module ctsp_char_checker #(
    parameter int LINE_BITS = 24,
    parameter int COL_BITS  = 16,
    parameter int DATA_W    = ((8 + LINE_BITS + COL_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_byte
    input  logic              s_tlast,   // end_of_input
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,   // out_char, line_no, column_no, zero fill
    input  logic              m_tlast,   // last_of_run
    output int                mismatch_count,
    output int                pending_chars
);
    import ctsp_pkg::*;

    typedef struct packed {
        logic [7:0]           char_code;
        logic [LINE_BITS-1:0] line_no;
        logic [COL_BITS-1:0]  column_no;
        logic                 ends_run;
    } tagged_char_t;

    // Characters still owed by the block, oldest first.
    tagged_char_t expected_chars [$];

    // Our own copy of the lookahead and the position counters.
    pend_t                held;
    logic [LINE_BITS-1:0] line_cnt;
    logic [COL_BITS-1:0]  col_cnt;

    initial begin
        mismatch_count = 0;
        pending_chars  = 0;
        held           = PK_NONE;
        line_cnt       = LINE_BITS'(1);
        col_cnt        = '0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Replacement for the third character of a trigraph; bit 8 says it is one.
    function automatic logic [8:0] trigraph_replacement(logic [7:0] b);
        case (b)
            CH_EQ:    return {1'b1, CH_HASH};
            CH_LPAR:  return {1'b1, CH_LBRK};
            CH_RPAR:  return {1'b1, CH_RBRK};
            CH_SLASH: return {1'b1, CH_BSL};
            CH_APOS:  return {1'b1, CH_CARET};
            CH_LT:    return {1'b1, CH_LBRC};
            CH_GT:    return {1'b1, CH_RBRC};
            CH_EXCL:  return {1'b1, CH_BAR};
            CH_MINUS: return {1'b1, CH_TILDE};
            default:  return {1'b0, b};
        endcase
    endfunction

    // Advance the position; both counters stop at all ones.
    function automatic void move_position(act_t how);
        logic [COL_BITS:0] sum;
        int                step;
        if (how == ACT_NEWLINE) begin
            if (line_cnt != '1) line_cnt = line_cnt + LINE_BITS'(1);
            col_cnt = '0;
        end else begin
            step    = (how == ACT_COL3) ? 3 : 1;
            sum     = {1'b0, col_cnt} + (COL_BITS + 1)'(step);
            col_cnt = sum[COL_BITS] ? '1 : sum[COL_BITS-1:0];
        end
    endfunction

    function automatic void put_char(logic [7:0] c, act_t how);
        move_position(how);
        expected_chars.push_back('{char_code: c, line_no: line_cnt,
                                   column_no: col_cnt, ends_run: 1'b0});
    endfunction

    // A byte seen with nothing held: marks and backslashes wait for more.
    function automatic void fresh_byte(logic [7:0] b);
        if (b == CH_QMARK) begin
            held = PK_Q1;
        end else if (b == CH_BSL) begin
            held = PK_BSL;
        end else if (b == CH_NL) begin
            put_char(b, ACT_NEWLINE);
        end else begin
            put_char(b, ACT_COL1);
        end
    endfunction

    // Everything one accepted input word releases, the last one flagged.
    function automatic void translate_word(logic [7:0] b, logic eoi);
        int           first;
        logic [8:0]   tri_hit;
        tagged_char_t tail;
        first = expected_chars.size();
        if (eoi) begin
            // End of input flushes held bytes as plain characters.
            case (held)
                PK_Q1:  put_char(CH_QMARK, ACT_COL1);
                PK_Q2: begin
                    put_char(CH_QMARK, ACT_COL1);
                    put_char(CH_QMARK, ACT_COL1);
                end
                PK_BSL: put_char(CH_BSL, ACT_COL1);
                default: ;
            endcase
            held = PK_NONE;
        end else begin
            case (held)
                PK_NONE: fresh_byte(b);
                PK_Q1: begin
                    if (b == CH_QMARK) begin
                        held = PK_Q2;
                    end else begin
                        held = PK_NONE;
                        put_char(CH_QMARK, ACT_COL1);
                        fresh_byte(b);
                    end
                end
                PK_Q2: begin
                    tri_hit = trigraph_replacement(b);
                    if (tri_hit[8]) begin
                        // A trigraph backslash goes out at once and never splices.
                        held = PK_NONE;
                        put_char(tri_hit[7:0], ACT_COL3);
                    end else if (b == CH_QMARK) begin
                        put_char(CH_QMARK, ACT_COL1);
                    end else begin
                        held = PK_NONE;
                        put_char(CH_QMARK, ACT_COL1);
                        put_char(CH_QMARK, ACT_COL1);
                        fresh_byte(b);
                    end
                end
                default: begin
                    // Held backslash: a newline makes a splice, anything else
                    // releases the backslash and is taken afresh.
                    held = PK_NONE;
                    if (b == CH_NL) begin
                        move_position(ACT_NEWLINE);
                    end else begin
                        put_char(CH_BSL, ACT_COL1);
                        fresh_byte(b);
                    end
                end
            endcase
        end
        if (expected_chars.size() > first) begin
            tail          = expected_chars.pop_back();
            tail.ends_run = 1'b1;
            expected_chars.push_back(tail);
        end
    endfunction

    // Compare released words first, then predict from the accepted input word.
    always @(posedge aclk) begin : watch
        tagged_char_t want;
        if (!aresetn) begin
            held     = PK_NONE;
            line_cnt = LINE_BITS'(1);
            col_cnt  = '0;
            expected_chars.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", m_tdata[7:0]));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[7:0] !== want.char_code)
                        report_mismatch($sformatf("char %h, wanted %h",
                                                  m_tdata[7:0], want.char_code));
                    if (m_tdata[8 +: LINE_BITS] !== want.line_no)
                        report_mismatch($sformatf("line %0d, wanted %0d",
                                                  m_tdata[8 +: LINE_BITS], want.line_no));
                    if (m_tdata[8 + LINE_BITS +: COL_BITS] !== want.column_no)
                        report_mismatch($sformatf("column %0d, wanted %0d",
                                                  m_tdata[8 + LINE_BITS +: COL_BITS],
                                                  want.column_no));
                    if (m_tlast !== want.ends_run)
                        report_mismatch($sformatf("last flag %b, wanted %b",
                                                  m_tlast, want.ends_run));
                end
            end
            if (s_tvalid && s_tready) translate_word(s_tdata, s_tlast);
        end
        pending_chars = expected_chars.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the trigraph and splice testbench: clock, reset, source words and
// receiver back-pressure. Depends on ctsp_pkg, the block and ctsp_char_checker.
module tb;
    import ctsp_pkg::*;

    localparam int LINE_BITS   = 24;
    localparam int COL_BITS    = 16;
    localparam int DATA_W      = ((8 + LINE_BITS + COL_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 120;
    localparam int LONG_LINE   = 40;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'h00;   // in_byte
    logic              s_tlast  = 1'b0;    // end_of_input
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;            // out_char, line_no, column_no, zero fill
    logic              m_tlast;            // last_of_run

    int mismatch_count;
    int pending_chars;
    int cycle_count   = 0;
    int words_sent    = 0;
    bit tx_gaps_on    = 1'b1;
    bit rx_gaps_on    = 1'b1;
    bit hold_off_req  = 1'b0;

    logic [7:0] trigraph_thirds [$] = '{CH_EQ, CH_LPAR, CH_RPAR, CH_SLASH, CH_APOS,
                                        CH_LT, CH_GT, CH_EXCL, CH_MINUS};

    c_trigraph_splice_position #(
        .LINE_BITS(LINE_BITS),
        .COL_BITS (COL_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    ctsp_char_checker #(
        .LINE_BITS(LINE_BITS),
        .COL_BITS (COL_BITS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .pending_chars (pending_chars)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on a cycle counter.
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stall bursts, long ready stretches, and one long hold-off.
    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else if ($urandom_range(0, 15) == 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic eoi);
        @(negedge aclk);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eoi;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // One short source fragment: trigraphs, splices, held bytes, newlines, end markers or plain bytes.
    task automatic send_fragment();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
            send_word(CH_QMARK, 1'b0);
            send_word(CH_QMARK, 1'b0);
            if ($urandom_range(0, 3) == 0) send_word(CH_QMARK, 1'b0);
            if ($urandom_range(0, 4) == 0)
                send_word(8'($urandom), 1'b0);
            else
                send_word(trigraph_thirds[$urandom_range(0, 8)], 1'b0);
        end else if (kind < 8) begin
            send_word(CH_QMARK, 1'b0);
            send_word(8'($urandom), 1'b0);
        end else if (kind < 10) begin
            send_word(CH_BSL, 1'b0);
            send_word(CH_NL, 1'b0);
        end else if (kind < 12) begin
            send_word(CH_BSL, 1'b0);
            send_word(8'($urandom), 1'b0);
        end else if (kind < 14) begin
            send_word(CH_NL, 1'b0);
        end else if (kind == 14) begin
            // End marker, often with something held in front of it.
            case ($urandom_range(0, 3))
                0: send_word(CH_QMARK, 1'b0);
                1: begin
                    send_word(CH_QMARK, 1'b0);
                    send_word(CH_QMARK, 1'b0);
                end
                2: send_word(CH_BSL, 1'b0);
                default: ;
            endcase
            send_word(8'($urandom), 1'b1);
        end else begin
            send_word(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_random(input int count);
        int mark;
        mark = words_sent;
        while (words_sent < mark + count) send_fragment();
    endtask

    initial begin : stimulus
        logic [8:0] opening_words [$];
        logic [7:0] filler;
        int         i;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening: {end marker, byte} per word.
        opening_words = '{
            {1'b0, CH_QMARK}, {1'b0, CH_QMARK}, {1'b0, CH_QMARK}, {1'b0, CH_MINUS},
            {1'b0, CH_QMARK}, {1'b0, 8'h00},
            {1'b0, CH_QMARK}, {1'b0, CH_QMARK}, {1'b0, 8'hFF},
            {1'b0, CH_QMARK}, {1'b0, CH_QMARK}, {1'b0, CH_SLASH}, {1'b0, CH_NL},
            {1'b0, CH_BSL}, {1'b0, CH_NL},
            {1'b0, CH_BSL}, {1'b0, CH_BSL}, {1'b0, CH_NL},
            {1'b0, CH_QMARK}, {1'b1, 8'hFF},
            {1'b0, CH_QMARK}, {1'b0, CH_QMARK}, {1'b1, 8'h00},
            {1'b0, CH_BSL}, {1'b1, 8'hFF},
            {1'b1, 8'h5A}
        };
        foreach (opening_words[k]) send_word(opening_words[k][7:0], opening_words[k][8]);

        send_random(150);

        // Stall the receiver for a long stretch while words keep coming.
        hold_off_req = 1'b1;
        tx_gaps_on   = 1'b0;
        send_random(40);
        tx_gaps_on   = 1'b1;

        send_random(140);

        // A longer line of plain characters closed by a trigraph.
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_word(8'h00, 1'b1);
        send_word(CH_NL, 1'b0);
        for (i = 0; i < LONG_LINE; i++) begin
            filler = 8'($urandom);
            if (filler == CH_QMARK || filler == CH_BSL || filler == CH_NL) filler = CH_HASH;
            send_word(filler, 1'b0);
        end
        send_word(CH_QMARK, 1'b0);
        send_word(CH_QMARK, 1'b0);
        send_word(CH_EQ, 1'b0);
        send_random(30);
        send_word(CH_NL, 1'b0);

        // Final stretch with both sides always ready.
        send_random(50);
        send_word(8'($urandom), 1'b1);

        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        wait (pending_chars == 0);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_chars == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: c_trigraph_splice_position.f
+incdir+design
design/ctsp_pkg.sv
design/ctsp_front.sv
design/ctsp_queue.sv
design/ctsp_back.sv
design/c_trigraph_splice_position.sv
verif/ctsp_char_checker.sv
verif/tb.sv
